// File: design/base64_stream_codec_assert.svh
// assertion macros shared by the checker of the base64 stream codec
`ifndef BASE64_STREAM_CODEC_ASSERT_SVH
`define BASE64_STREAM_CODEC_ASSERT_SVH

// same-cycle implication, sampled on clk, off during reset
`define B64_AST_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("b64 check failed");

// next-cycle implication, sampled on clk, off during reset
`define B64_AST_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("b64 check failed");

`endif

// File: design/b64_pkg.sv
// shared types, constants and alphabet functions of the base64 codec
package b64_pkg;

  localparam int unsigned QDepth = 2;
  localparam int unsigned QAw    = (QDepth > 1) ? $clog2(QDepth) : 1;
  localparam int unsigned QCw    = $clog2(QDepth + 1);

  localparam int unsigned CfgAw  = 3;
  localparam int unsigned CfgDw  = 32;

  localparam logic [7:0] PadChar = 8'h3D;

  localparam logic [1:0] StOk     = 2'd0;
  localparam logic [1:0] StBadLen = 2'd1;
  localparam logic [1:0] StBadChr = 2'd2;

  localparam logic ModeEnc = 1'b0;
  localparam logic ModeDec = 1'b1;

  // register index of mode, taken from paddr word bit
  localparam logic RegMode = 1'b0;

  // one finished group handed from front to back
  typedef struct packed {
    logic        enc;
    logic [23:0] bits;
    logic [2:0]  n_out;
    logic [2:0]  n_data;
    logic        last;
    logic [1:0]  status;
  } b64_grp_t;

  // control from the register block to the front
  typedef struct packed {
    logic mode;
    logic clr;
  } b64_ctl_t;

  function automatic logic [7:0] b64_char(input logic [5:0] s);
    logic [7:0] r;
    if (s < 6'd26) begin
      r = 8'd65 + {2'b00, s};
    end else if (s < 6'd52) begin
      r = 8'd97 + {2'b00, s} - 8'd26;
    end else if (s < 6'd62) begin
      r = 8'd48 + {2'b00, s} - 8'd52;
    end else if (s == 6'd62) begin
      r = 8'h2B;
    end else begin
      r = 8'h2F;
    end
    return r;
  endfunction

  // returns {ok, sextet}
  function automatic logic [6:0] b64_sextet(input logic [7:0] c);
    logic [7:0] t;
    logic [6:0] r;
    t = 8'd0;
    r = 7'd0;
    if (c >= 8'd65 && c <= 8'd90) begin
      t = c - 8'd65;
      r = {1'b1, t[5:0]};
    end else if (c >= 8'd97 && c <= 8'd122) begin
      t = c - 8'd97 + 8'd26;
      r = {1'b1, t[5:0]};
    end else if (c >= 8'd48 && c <= 8'd57) begin
      t = c - 8'd48 + 8'd52;
      r = {1'b1, t[5:0]};
    end else if (c == 8'h2B) begin
      r = {1'b1, 6'd62};
    end else if (c == 8'h2F) begin
      r = {1'b1, 6'd63};
    end
    return r;
  endfunction

endpackage

// File: design/b64_fifo.sv
// short group queue between the front and the back
module b64_fifo (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  b64_pkg::b64_grp_t  push_data,
  input  logic               pop,
  output b64_pkg::b64_grp_t  head,
  output logic               full,
  output logic               empty
);
  import b64_pkg::*;

  b64_grp_t           mem_r [QDepth];
  logic [QAw-1:0]     wr_ptr_r, wr_ptr_nxt;
  logic [QAw-1:0]     rd_ptr_r, rd_ptr_nxt;
  logic [QCw-1:0]     cnt_r, cnt_nxt;
  logic               do_push, do_pop;

  assign full    = (cnt_r == QCw'(QDepth));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == QAw'(QDepth - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == QAw'(QDepth - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// File: design/b64_front.sv
// front: accepts beats, builds groups and quads, hands finished groups to the queue
module b64_front (
  input  logic               clk,
  input  logic               rst_n,
  input  b64_pkg::b64_ctl_t  ctl,
  input  logic               in_valid,
  input  logic [7:0]         in_byte,
  input  logic               in_last,
  output logic               in_ready,
  input  logic               q_full,
  output logic               push,
  output b64_pkg::b64_grp_t  push_data
);
  import b64_pkg::*;

  logic [23:0] gb_r, gb_nxt;
  logic [1:0]  cnt_r, cnt_nxt;
  logic [1:0]  pad_r, pad_nxt;
  logic        bad_r, bad_nxt;

  logic        acc;
  logic [23:0] gb_enc;
  logic [2:0]  held;
  logic [6:0]  sx_ok;
  logic        is_pad;
  logic [5:0]  sx;
  logic [1:0]  pad_upd;
  logic        bad_upd;
  logic [2:0]  n_dec;

  assign in_ready = !q_full;
  assign acc      = in_valid && in_ready;

  always_comb begin
    unique case (cnt_r)
      2'd0:    gb_enc = gb_r | {in_byte, 16'h0000};
      2'd1:    gb_enc = gb_r | {8'h00, in_byte, 8'h00};
      default: gb_enc = gb_r | {16'h0000, in_byte};
    endcase
  end

  assign held    = {1'b0, cnt_r} + 3'd1;
  assign sx_ok   = b64_sextet(in_byte);
  assign is_pad  = (in_byte == PadChar);
  assign sx      = is_pad ? 6'd0 : sx_ok[5:0];
  assign pad_upd = pad_r | {is_pad && (cnt_r == 2'd2), is_pad && (cnt_r == 2'd3)};
  assign bad_upd = bad_r | (!is_pad && !sx_ok[6]);
  assign n_dec   = in_last ? (3'd3 - {2'b00, pad_upd[1]} - {2'b00, pad_upd[0]}) : 3'd3;

  always_comb begin
    gb_nxt    = gb_r;
    cnt_nxt   = cnt_r;
    pad_nxt   = pad_r;
    bad_nxt   = bad_r;
    push      = 1'b0;
    push_data = '0;
    if (ctl.clr) begin
      gb_nxt  = '0;
      cnt_nxt = '0;
      pad_nxt = '0;
      bad_nxt = 1'b0;
    end else if (acc) begin
      if (ctl.mode == ModeEnc) begin
        if (held < 3'd3 && !in_last) begin
          gb_nxt  = gb_enc;
          cnt_nxt = held[1:0];
        end else begin
          push             = 1'b1;
          push_data.enc    = 1'b1;
          push_data.bits   = gb_enc;
          push_data.n_out  = 3'd4;
          push_data.n_data = held + 3'd1;
          push_data.last   = in_last;
          push_data.status = StOk;
          gb_nxt  = '0;
          cnt_nxt = '0;
          pad_nxt = '0;
          bad_nxt = 1'b0;
        end
      end else begin
        if (cnt_r != 2'd3) begin
          if (in_last) begin
            // incomplete final quad: one bad-length beat
            push             = 1'b1;
            push_data.n_out  = 3'd1;
            push_data.last   = 1'b1;
            push_data.status = StBadLen;
            gb_nxt  = '0;
            cnt_nxt = '0;
            pad_nxt = '0;
            bad_nxt = 1'b0;
          end else begin
            gb_nxt  = {gb_r[17:0], sx};
            cnt_nxt = cnt_r + 2'd1;
            pad_nxt = pad_upd;
            bad_nxt = bad_upd;
          end
        end else begin
          push             = 1'b1;
          push_data.bits   = {gb_r[17:0], sx};
          push_data.n_out  = n_dec;
          push_data.n_data = n_dec;
          push_data.last   = in_last;
          push_data.status = bad_upd ? StBadChr : StOk;
          gb_nxt  = '0;
          cnt_nxt = '0;
          pad_nxt = '0;
          bad_nxt = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gb_r  <= '0;
      cnt_r <= '0;
      pad_r <= '0;
      bad_r <= 1'b0;
    end else begin
      gb_r  <= gb_nxt;
      cnt_r <= cnt_nxt;
      pad_r <= pad_nxt;
      bad_r <= bad_nxt;
    end
  end

endmodule

// File: design/b64_back.sv
// back: walks the head group into the output register one result beat per cycle while out_ready allows
module b64_back (
  input  logic               clk,
  input  logic               rst_n,
  input  b64_pkg::b64_grp_t  head,
  input  logic               q_empty,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [7:0]         out_byte,
  output logic               out_last,
  output logic [1:0]         out_status
);
  import b64_pkg::*;

  logic        ov_r, ov_nxt;
  logic [1:0]  idx_r, idx_nxt;
  logic [7:0]  byte_r;
  logic        last_r;
  logic [1:0]  st_r;

  logic        load;
  logic [2:0]  idx3;
  logic        last_beat;
  logic [5:0]  sx;
  logic [7:0]  dbyte;
  logic [7:0]  beat_byte;

  assign load      = (!ov_r || out_ready) && !q_empty;
  assign idx3      = {1'b0, idx_r};
  assign last_beat = (idx3 == head.n_out - 3'd1);
  assign pop       = load && last_beat;

  always_comb begin
    unique case (idx_r)
      2'd0:    sx = head.bits[23:18];
      2'd1:    sx = head.bits[17:12];
      2'd2:    sx = head.bits[11:6];
      default: sx = head.bits[5:0];
    endcase
    unique case (idx_r)
      2'd0:    dbyte = head.bits[23:16];
      2'd1:    dbyte = head.bits[15:8];
      default: dbyte = head.bits[7:0];
    endcase
    if (head.enc) begin
      beat_byte = (idx3 < head.n_data) ? b64_char(sx) : PadChar;
    end else begin
      beat_byte = dbyte;
    end
  end

  always_comb begin
    ov_nxt  = ov_r;
    idx_nxt = idx_r;
    if (load) begin
      ov_nxt  = 1'b1;
      idx_nxt = last_beat ? 2'd0 : idx_r + 2'd1;
    end else if (out_ready) begin
      ov_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r  <= 1'b0;
      idx_r <= '0;
    end else begin
      ov_r  <= ov_nxt;
      idx_r <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      byte_r <= beat_byte;
      last_r <= last_beat && head.last;
      st_r   <= head.status;
    end
  end

  assign out_valid  = ov_r;
  assign out_byte   = byte_r;
  assign out_last   = last_r;
  assign out_status = st_r;

endmodule

// File: design/base64_stream_codec.sv
// top level of the streaming base64 encoder / decoder
// a completed group is queued, then its first result beat loads the back's output register
// throughput: one result beat per cycle while out_tready is high; encode makes four
//   result beats per three input beats; decode keeps up with one input beat per cycle
// input beats are taken one per cycle while the two-entry group queue has room
// reset (rst_n low, synchronous) clears mode to encode, the partial group and the queue
module base64_stream_codec (
  input  logic                        clk,
  input  logic                        rst_n,
  // input stream
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [7:0]                  in_tdata,   // [7:0] in_byte
  input  logic                        in_tlast,
  // result stream
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [7:0]                  out_tdata,  // [7:0] out_byte
  output logic                        out_tlast,
  output logic [1:0]                  out_tuser,  // [1:0] status
  // register port
  input  logic                        cfg_psel,
  input  logic                        cfg_penable,
  input  logic                        cfg_pwrite,
  input  logic [b64_pkg::CfgAw-1:0]   cfg_paddr,
  input  logic [b64_pkg::CfgDw-1:0]   cfg_pwdata,
  output logic [b64_pkg::CfgDw-1:0]   cfg_prdata,
  output logic                        cfg_pready
);
  import b64_pkg::*;

  // mode register, word 0
  logic      mode_r, mode_nxt;
  logic      cfg_wr;
  b64_ctl_t  ctl;

  // queue handshake
  logic      q_push, q_pop, q_full, q_empty;
  b64_grp_t  q_in, q_head;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite &&
                      (cfg_paddr[2] == RegMode);
  assign cfg_prdata = {{(CfgDw-1){1'b0}}, mode_r};

  assign mode_nxt = cfg_wr ? cfg_pwdata[0] : mode_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= ModeEnc;
    end else begin
      mode_r <= mode_nxt;
    end
  end

  // a mode write also drops any partial group
  assign ctl.mode = mode_r;
  assign ctl.clr  = cfg_wr;

  b64_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (ctl),
    .in_valid  (in_tvalid),
    .in_byte   (in_tdata),
    .in_last   (in_tlast),
    .in_ready  (in_tready),
    .q_full    (q_full),
    .push      (q_push),
    .push_data (q_in)
  );

  b64_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_in),
    .pop       (q_pop),
    .head      (q_head),
    .full      (q_full),
    .empty     (q_empty)
  );

  b64_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (q_head),
    .q_empty    (q_empty),
    .pop        (q_pop),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_byte   (out_tdata),
    .out_last   (out_tlast),
    .out_status (out_tuser)
  );

endmodule

// File: design/b64_checker.sv
// port-level checker of the base64 codec and its bind
`include "base64_stream_codec_assert.svh"

module b64_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        out_tvalid,
  input logic                        out_tready,
  input logic [7:0]                  out_tdata,
  input logic                        out_tlast,
  input logic [1:0]                  out_tuser,
  input logic                        cfg_psel,
  input logic                        cfg_penable,
  input logic                        cfg_pwrite,
  input logic [b64_pkg::CfgAw-1:0]   cfg_paddr,
  input logic [b64_pkg::CfgDw-1:0]   cfg_pwdata,
  input logic [b64_pkg::CfgDw-1:0]   cfg_prdata
);
  import b64_pkg::*;

  // status never takes the unused code
  `B64_AST_IMP(a_status_code, out_tvalid, out_tuser != 2'd3)

  // a bad-length beat is a lone zero byte that closes the message
  `B64_AST_IMP(a_badlen_form, out_tvalid && out_tuser == StBadLen,
    out_tlast && out_tdata == 8'd0)

  // a stalled result beat holds
  `B64_AST_NXT(a_out_hold, out_tvalid && !out_tready,
    out_tvalid && $stable(out_tdata) && $stable(out_tlast) && $stable(out_tuser))

  // only the mode bit reads back, and a write to it shows on the next cycle
  `B64_AST_NXT(a_mode_read,
    cfg_psel && cfg_penable && cfg_pwrite && cfg_paddr[2] == RegMode,
    cfg_prdata == {{(CfgDw-1){1'b0}}, $past(cfg_pwdata[0])})

endmodule

bind base64_stream_codec b64_checker u_b64_checker (.*);
